// File: src/mvpv_pkg.sv
// Shared types, constants and code tables of the motion vector pair VLC decoder.
`default_nettype none

package mvpv_pkg;

    // Look-ahead window and the slice that one component's code can span.
    localparam int WinBits     = 26;
    localparam int CompWinBits = 13;
    localparam int LenBits     = 4;
    localparam int UsedBits    = 5;

    // Escape codes carry an 8-bit field that is offset by 128.
    localparam int EscPrefixBits = 5;
    localparam int EscFieldBits  = 8;
    localparam logic [EscFieldBits-1:0] EscOffset = 8'h80;
    localparam logic [LenBits-1:0] EscCodeLen = LenBits'(EscPrefixBits + EscFieldBits);

    typedef logic signed [7:0]        mv_t;
    typedef logic [LenBits-1:0]       len_t;
    typedef logic [UsedBits-1:0]      used_t;
    typedef logic [CompWinBits-1:0]   comp_win_t;
    typedef logic [WinBits-1:0]       win_t;

    // Result of decoding a single component.
    typedef struct packed {
        mv_t  val;
        len_t len;
        logic ok;
    } comp_dec_t;

    // Result of decoding a pair, as it goes into the result register.
    typedef struct packed {
        mv_t   first;
        mv_t   second;
        used_t bits_used;
        logic  code_error;
    } pair_res_t;

    // Values of the 9-bit codes, indexed by their last three bits.
    localparam mv_t GrpA [8] = '{-8'sd18, -8'sd20, -8'sd19, -8'sd21,
                                 8'sd19, 8'sd21, 8'sd20, 8'sd22};
    localparam mv_t GrpB [8] = '{-8'sd22, -8'sd24, -8'sd23, -8'sd25,
                                 8'sd23, 8'sd25, 8'sd24, 8'sd26};
    localparam mv_t GrpC [8] = '{-8'sd26, -8'sd28, -8'sd27, -8'sd29,
                                 8'sd27, 8'sd29, 8'sd28, 8'sd30};
    localparam mv_t GrpD [8] = '{-8'sd30, -8'sd32, -8'sd31, 8'sd16,
                                 8'sd31, 8'sd0, 8'sd32, 8'sd0};

    // Last three bits of the two codewords that have no meaning.
    localparam logic [2:0] BadTailLo = 3'd5;
    localparam logic [2:0] BadTailHi = 3'd7;

endpackage

`default_nettype wire

// File: src/mvpv_comp_dec.sv
// Code tree decoder for one motion vector component.
`default_nettype none

module mvpv_comp_dec (
    input  wire  mvpv_pkg::comp_win_t code_bits,
    output       mvpv_pkg::comp_dec_t dec
);
    import mvpv_pkg::*;

    mv_t       val;
    len_t      len;
    logic      ok;
    comp_win_t w;

    assign w = code_bits;

    always_comb
    begin
        val = 8'sd0;
        len = '0;
        ok  = 1'b1;
        unique case (w[12:11])
            2'b00:
            begin
                priority if (w[10])
                begin
                    val = -8'sd1; len = 4'd3;
                end
                else if (!w[9])
                begin
                    val = 8'sd2; len = 4'd4;
                end
                else if (w[8])
                begin
                    val = 8'sd3; len = 4'd5;
                end
                else if (!w[7])
                begin
                    val = 8'sd6; len = 4'd6;
                end
                else if (w[6])
                begin
                    val = -8'sd9; len = 4'd7;
                end
                else
                begin
                    val = w[5] ? 8'sd12 : -8'sd12; len = 4'd8;
                end
            end
            2'b01:
            begin
                val = 8'sd0; len = 4'd2;
            end
            2'b10:
            begin
                if (w[10])
                begin
                    val = 8'sd1; len = 4'd3;
                end
                else
                begin
                    unique case (w[9:8])
                        2'b00:
                        begin
                            priority if (!w[7])
                            begin
                                val = -8'sd5; len = 4'd6;
                            end
                            else if (w[6])
                            begin
                                val = 8'sd9; len = 4'd7;
                            end
                            else if (w[5])
                            begin
                                val = w[4] ? 8'sd15 : -8'sd15; len = 4'd9;
                            end
                            else
                            begin
                                val = -8'sd11; len = 4'd8;
                            end
                        end
                        2'b01:
                        begin
                            // Escape: the field minus 128 is the field with its top bit flipped.
                            val = mv_t'(w[EscFieldBits-1:0] ^ EscOffset);
                            len = EscCodeLen;
                        end
                        2'b10:
                        begin
                            priority if (!w[7])
                            begin
                                val = 8'sd5; len = 4'd6;
                            end
                            else if (!w[6])
                            begin
                                val = -8'sd8; len = 4'd7;
                            end
                            else
                            begin
                                val = w[5] ? -8'sd10 : 8'sd11; len = 4'd8;
                            end
                        end
                        default:
                        begin
                            val = w[7] ? 8'sd4 : -8'sd4; len = 4'd6;
                        end
                    endcase
                end
            end
            default:
            begin
                unique case (w[10:9])
                    2'b00:
                    begin
                        if (w[8])
                        begin
                            val = -8'sd3; len = 4'd5;
                        end
                        else
                        begin
                            val = w[7] ? -8'sd6 : 8'sd7; len = 4'd6;
                        end
                    end
                    2'b10:
                    begin
                        val = -8'sd2; len = 4'd4;
                    end
                    2'b01:
                    begin
                        unique case (w[8:7])
                            2'b00:
                            begin
                                if (w[6])
                                begin
                                    val = 8'sd10; len = 4'd7;
                                end
                                else
                                begin
                                    val = w[5] ? -8'sd13 : -8'sd14; len = 4'd8;
                                end
                            end
                            2'b01:
                            begin
                                unique case (w[6:5])
                                    2'b00:
                                    begin
                                        val = 8'sd14; len = 4'd8;
                                    end
                                    2'b10:
                                    begin
                                        val = 8'sd13; len = 4'd8;
                                    end
                                    2'b01:
                                    begin
                                        val = w[4] ? 8'sd17 : -8'sd16; len = 4'd9;
                                    end
                                    default:
                                    begin
                                        val = w[4] ? 8'sd18 : -8'sd17; len = 4'd9;
                                    end
                                endcase
                            end
                            2'b10:
                            begin
                                val = 8'sd8; len = 4'd6;
                            end
                            default:
                            begin
                                val = GrpA[w[6:4]]; len = 4'd9;
                            end
                        endcase
                    end
                    default:
                    begin
                        unique case (w[8:7])
                            2'b01:
                            begin
                                val = -8'sd7; len = 4'd6;
                            end
                            2'b00:
                            begin
                                val = GrpB[w[6:4]]; len = 4'd9;
                            end
                            2'b10:
                            begin
                                val = GrpC[w[6:4]]; len = 4'd9;
                            end
                            default:
                            begin
                                len = 4'd9;
                                if (w[6:4] == BadTailLo || w[6:4] == BadTailHi)
                                begin
                                    val = 8'sd0; ok = 1'b0;
                                end
                                else
                                begin
                                    val = GrpD[w[6:4]];
                                end
                            end
                        endcase
                    end
                endcase
            end
        endcase
    end

    assign dec = '{val: val, len: len, ok: ok};

endmodule

`default_nettype wire

// File: src/mvpv_pair_dec.sv
// Decodes both components of a pair: first code, bit alignment, second code.
`default_nettype none

module mvpv_pair_dec (
    input  wire  mvpv_pkg::win_t      window,
    output       mvpv_pkg::pair_res_t res
);
    import mvpv_pkg::*;

    comp_dec_t dec_first;
    comp_dec_t dec_second;
    win_t      aligned;
    logic      pair_ok;
    used_t     total_len;

    mvpv_comp_dec u_dec_first (
        .code_bits (window[WinBits-1 -: CompWinBits]),
        .dec       (dec_first)
    );

    // The second code starts right after the first one.
    assign aligned = window << dec_first.len;

    mvpv_comp_dec u_dec_second (
        .code_bits (aligned[WinBits-1 -: CompWinBits]),
        .dec       (dec_second)
    );

    assign pair_ok   = dec_first.ok && dec_second.ok;
    assign total_len = used_t'(dec_first.len) + used_t'(dec_second.len);

    always_comb
    begin
        res.first      = dec_first.ok ? dec_first.val : 8'sd0;
        res.second     = pair_ok ? dec_second.val : 8'sd0;
        res.bits_used  = pair_ok ? total_len : '0;
        res.code_error = !pair_ok;
    end

endmodule

`default_nettype wire

// File: src/motion_vector_pair_vlc_decode.sv
// Top level of the motion vector pair VLC decoder: input register, decode, result register.
// A window is decoded from the input register; its result waits in the result register.
// Throughput: one pair per cycle unless the output stalls, set by the single-pass decode.
// A stalled output holds the result register, and the input register once it holds a window.
// Reset (rst_n, asynchronous, active low) empties both registers; no other state is kept.
`default_nettype none

module motion_vector_pair_vlc_decode (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_ready,
    input  wire  mvpv_pkg::win_t   bit_window,
    output logic                   out_valid,
    input  wire                    out_ready,
    output       mvpv_pkg::mv_t    first_component,
    output       mvpv_pkg::mv_t    second_component,
    output       mvpv_pkg::used_t  bits_used,
    output logic                   code_error
);
    import mvpv_pkg::*;

    // Input register: holds the window of the pair being decoded.
    logic      win_valid_reg;
    win_t      win_reg;

    // Result register: holds the decoded pair until the output transfer.
    logic      res_valid_reg;
    pair_res_t res_reg;

    pair_res_t res_next;
    logic      res_advance;

    mvpv_pair_dec u_pair_dec (
        .window (win_reg),
        .res    (res_next)
    );

    // The result register can take a new pair when it is empty or being drained.
    assign res_advance = !res_valid_reg || out_ready;
    // The input register can take a new window when it is empty or moves on this cycle.
    assign in_ready    = !win_valid_reg || res_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                win_valid_reg <= in_valid;
            end
            if (res_advance)
            begin
                res_valid_reg <= win_valid_reg;
            end
        end
    end

    // Payload registers carry no reset; the valid bits qualify them.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            win_reg <= bit_window;
        end
        if (res_advance && win_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid        = res_valid_reg;
    assign first_component  = res_reg.first;
    assign second_component = res_reg.second;
    assign bits_used        = res_reg.bits_used;
    assign code_error       = res_reg.code_error;

`ifndef ASSERT_OFF
    // A failed pair never reports consumed bits.
    a_err_no_bits: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && code_error) |-> (bits_used == '0))
        else $error("error result reports consumed bits");

    // A good pair consumes at least two minimal codes.
    a_ok_min_bits: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !code_error) |-> (bits_used >= used_t'(4)))
        else $error("good result reports too few bits");

    // The input side stalls only when both registers are full.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (win_valid_reg && res_valid_reg))
        else $error("input stalled with room in the pipeline");

    // A pair waiting in the input register is not dropped while the output stalls.
    a_hold_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (win_valid_reg && !res_advance) |=> win_valid_reg)
        else $error("pending pair lost during output stall");
`endif

endmodule

`default_nettype wire

// File: test/motion_vector_pair_vlc_decode_tb.sv
// Self-checking testbench for the motion vector pair VLC decoder.
`timescale 1ns / 1ps

module motion_vector_pair_vlc_decode_tb;

    import mvpv_pkg::*;

    // A run with no transfer on either side for this many cycles is hung.
    localparam int StallLimit = 1000;
    // A result passes the input register and the result register before it can transfer.
    localparam int DrainCycles = 8;
    localparam int RandomPerPhase = 243;
    localparam int NumDirected = 23;

    // Escape codes carry an 8-bit field stored with a bias.
    localparam int EscBias = 128;
    // Last three bits of the two 9-bit codewords that mean nothing.
    localparam int BadTailLow = 5;
    localparam int BadTailHigh = 7;

    // Values of the 9-bit codewords, indexed by their last three bits.
    localparam mv_t TailSetA [8] = '{-8'sd18, -8'sd20, -8'sd19, -8'sd21,
                                     8'sd19, 8'sd21, 8'sd20, 8'sd22};
    localparam mv_t TailSetB [8] = '{-8'sd22, -8'sd24, -8'sd23, -8'sd25,
                                     8'sd23, 8'sd25, 8'sd24, 8'sd26};
    localparam mv_t TailSetC [8] = '{-8'sd26, -8'sd28, -8'sd27, -8'sd29,
                                     8'sd27, 8'sd29, 8'sd28, 8'sd30};
    localparam mv_t TailSetD [8] = '{-8'sd30, -8'sd32, -8'sd31, 8'sd16,
                                     8'sd31, 8'sd0, 8'sd32, 8'sd0};

    // One row of the directed part. Rows with has_known set carry their
    // result typed in; the others are checked against the decoder model.
    typedef struct {
        win_t  window;
        bit    has_known;
        mv_t   first;
        mv_t   second;
        used_t used;
        logic  err;
    } stim_row_t;

    logic    clk;
    logic    rst_n;
    logic    in_valid;
    logic    in_ready;
    win_t    bit_window;
    logic    out_valid;
    logic    out_ready = 1'b0;
    mv_t     first_component;
    mv_t     second_component;
    used_t   bits_used;
    logic    code_error;

    // Decoded pairs waiting for their output transfer, oldest first.
    pair_res_t pending_pairs [$];
    pair_res_t arrived_want;
    int        error_count = 0;
    int        quiet_cycles = 0;
    // Chance, in percent, that the sender or the receiver holds back in a cycle.
    int        tx_idle_pct = 0;
    int        rx_idle_pct = 0;

    // Bit cursor of the decoder model. Only the stimulus process uses it.
    win_t      scan_win;
    int        scan_pos;

    motion_vector_pair_vlc_decode u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .bit_window       (bit_window),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .first_component  (first_component),
        .second_component (second_component),
        .bits_used        (bits_used),
        .code_error       (code_error)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Takes the next n bits of the window, first bit most significant.
    // A read past the end of the window delivers zeros.
    function automatic int take_bits(input int n);
        int v;
        v = 0;
        for (int i = 0; i < n; i++)
        begin
            v = v << 1;
            if (scan_pos < WinBits)
                v = v | int'(scan_win[WinBits - 1 - scan_pos]);
            scan_pos++;
        end
        return v;
    endfunction

    // Walks the code tree for one component from the cursor. Each if-else
    // chain reads one bit per test, in the order the stream presents them.
    // Returns 0 when the codeword is one of the two invalid 9-bit codes.
    function automatic bit decode_mv(output int val);
        int a;
        int b;
        int t;
        val = 0;
        case (take_bits(2))
            0:
            begin
                if (take_bits(1)) val = -1;
                else if (!take_bits(1)) val = 2;
                else if (take_bits(1)) val = 3;
                else if (!take_bits(1)) val = 6;
                else if (take_bits(1)) val = -9;
                else val = take_bits(1) ? 12 : -12;
                return 1'b1;
            end
            1:
            begin
                return 1'b1;
            end
            2:
            begin
                if (take_bits(1))
                begin
                    val = 1;
                    return 1'b1;
                end
                a = take_bits(2);
                case (a)
                    0:
                    begin
                        if (!take_bits(1)) val = -5;
                        else if (take_bits(1)) val = 9;
                        else if (take_bits(1)) val = take_bits(1) ? 15 : -15;
                        else val = -11;
                    end
                    // Escape: the value is carried in the next byte, stored with the bias EscBias.
                    1: val = take_bits(8) - EscBias;
                    2:
                    begin
                        if (!take_bits(1)) val = 5;
                        else if (!take_bits(1)) val = -8;
                        else val = take_bits(1) ? -10 : 11;
                    end
                    default: val = take_bits(1) ? 4 : -4;
                endcase
                return 1'b1;
            end
            default:
            begin
                a = take_bits(2);
                if (a == 0)
                begin
                    if (take_bits(1)) val = -3;
                    else val = take_bits(1) ? -6 : 7;
                    return 1'b1;
                end
                if (a == 2)
                begin
                    val = -2;
                    return 1'b1;
                end
                b = take_bits(2);
                if (a == 1)
                begin
                    case (b)
                        0:
                        begin
                            if (take_bits(1)) val = 10;
                            else val = take_bits(1) ? -13 : -14;
                        end
                        1:
                        begin
                            t = take_bits(2);
                            case (t)
                                0: val = 14;
                                2: val = 13;
                                1: val = take_bits(1) ? 17 : -16;
                                default: val = take_bits(1) ? 18 : -17;
                            endcase
                        end
                        2: val = 8;
                        default: val = TailSetA[take_bits(3)];
                    endcase
                    return 1'b1;
                end
                if (b == 1)
                begin
                    val = -7;
                    return 1'b1;
                end
                t = take_bits(3);
                if (b == 0)
                begin
                    val = TailSetB[t];
                    return 1'b1;
                end
                if (b == 2)
                begin
                    val = TailSetC[t];
                    return 1'b1;
                end
                if (t == BadTailLow || t == BadTailHigh)
                begin
                    val = 0;
                    return 1'b0;
                end
                val = TailSetD[t];
                return 1'b1;
            end
        endcase
        return 1'b1;
    endfunction

    // Expected result for one window. A bad first code stops the decode with
    // everything zero; a bad second code keeps the first value. Either error
    // reports no bits used.
    function automatic pair_res_t decode_pair(input win_t w);
        pair_res_t r;
        int v1;
        int v2;
        r = '0;
        scan_win = w;
        scan_pos = 0;
        if (!decode_mv(v1))
        begin
            r.code_error = 1'b1;
        end
        else if (!decode_mv(v2))
        begin
            r.first = mv_t'(v1);
            r.code_error = 1'b1;
        end
        else
        begin
            r.first = mv_t'(v1);
            r.second = mv_t'(v2);
            r.bits_used = used_t'(scan_pos);
        end
        return r;
    endfunction

    // Random windows. Plain random bits reach most of the tree; the rest
    // steer the front of the window toward escapes, the 9-bit groups and
    // invalid codes in either component.
    function automatic win_t random_window();
        win_t w;
        int pick;
        w = win_t'($urandom);
        pick = $urandom_range(9);
        case (pick)
            0, 1: w[25:21] = 5'b10001;
            2, 3: w[25:20] = 6'b111111;
            4: w[25:22] = 4'b1111;
            5: w[25:19] = 7'b0110001;
            6: w[25:16] = 10'b1110111111;
            default: ;
        endcase
        return w;
    endfunction

    task automatic note_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        error_count++;
    endtask

    // Presents one window, holding valid and the payload until the transfer,
    // then records what the block has to return for it.
    task automatic send_window(input win_t w, input pair_res_t want);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        bit_window <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_pairs.push_back(want);
    endtask

    // Output side: check the result at every output transfer, then pick
    // whether the receiver takes the next one. Values are sampled at the
    // edge before any update of this step lands.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pairs.size() == 0)
            begin
                note_mismatch("result transfer with no window pending");
            end
            else
            begin
                arrived_want = pending_pairs.pop_front();
                if (first_component !== arrived_want.first)
                    note_mismatch($sformatf("first_component got %0d want %0d",
                                            first_component, arrived_want.first));
                if (second_component !== arrived_want.second)
                    note_mismatch($sformatf("second_component got %0d want %0d",
                                            second_component, arrived_want.second));
                if (bits_used !== arrived_want.bits_used)
                    note_mismatch($sformatf("bits_used got %0d want %0d",
                                            bits_used, arrived_want.bits_used));
                if (code_error !== arrived_want.code_error)
                    note_mismatch($sformatf("code_error got %b want %b",
                                            code_error, arrived_want.code_error));
            end
        end
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Counts cycles without a transfer on either side.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < StallLimit)
            @(posedge clk);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        stim_row_t directed_rows [NumDirected];
        pair_res_t want;

        // Typed-in results: the plain zero stream, all ones, escapes at both
        // ends of their range, the shortest pair and the invalid codes in
        // either component. The rest walks the long codes and the groups.
        directed_rows = '{
            '{26'h0000000, 1'b1, 8'sd2, 8'sd2, 5'd8, 1'b0},
            '{26'h3FFFFFF, 1'b1, 8'sd0, 8'sd0, 5'd0, 1'b1},
            '{{5'b10001, 8'hFF, 5'b10001, 8'h00}, 1'b1, 8'sd127, -8'sd128, 5'd26, 1'b0},
            '{{5'b10001, 8'h00, 5'b10001, 8'hFF}, 1'b1, -8'sd128, 8'sd127, 5'd26, 1'b0},
            '{{5'b10001, 8'h80, 2'b01, 11'd0}, 1'b1, 8'sd0, 8'sd0, 5'd15, 1'b0},
            '{{2'b01, 2'b01, 22'd0}, 1'b1, 8'sd0, 8'sd0, 5'd4, 1'b0},
            '{{9'b111111101, 17'h1FFFF}, 1'b1, 8'sd0, 8'sd0, 5'd0, 1'b1},
            '{{9'b111111111, 17'd0}, 1'b1, 8'sd0, 8'sd0, 5'd0, 1'b1},
            '{{4'b1110, 9'b111111101, 13'd0}, 1'b1, -8'sd2, 8'sd0, 5'd0, 1'b1},
            '{{5'b10001, 8'h7F, 9'b111111111, 4'd0}, 1'b1, -8'sd1, 8'sd0, 5'd0, 1'b1},
            '{{6'b111111, 3'd0, 2'b01, 15'd0}, 1'b0, 8'sd0, 8'sd0, 5'd0, 1'b0},
            '{{6'b111111, 3'd1, 2'b01, 15'd0}, 1'b0, 8'sd0, 8'sd0, 5'd0, 1'b0},
            '{{6'b111111, 3'd2, 2'b01, 15'd0}, 1'b0, 8'sd0, 8'sd0, 5'd0, 1'b0},
            '{{6'b111111, 3'd3, 2'b01, 15'd0}, 1'b0, 8'sd0, 8'sd0, 5'd0, 1'b0},
            '{{6'b111111, 3'd4, 2'b01, 15'd0}, 1'b0, 8'sd0, 8'sd0, 5'd0, 1'b0},
            '{{6'b111111, 3'd6, 2'b01, 15'd0}, 1'b0, 8'sd0, 8'sd0, 5'd0, 1'b0},
            '{{6'b110111, 3'd7, 17'd0}, 1'b0, 8'sd0, 8'sd0, 5'd0, 1'b0},
            '{{6'b111100, 3'd3, 17'd0}, 1'b0, 8'sd0, 8'sd0, 5'd0, 1'b0},
            '{{6'b111110, 3'd4, 17'd0}, 1'b0, 8'sd0, 8'sd0, 5'd0, 1'b0},
            '{{6'b111101, 20'd0}, 1'b0, 8'sd0, 8'sd0, 5'd0, 1'b0},
            '{{8'b00010101, 8'b00010100, 10'd0}, 1'b0, 8'sd0, 8'sd0, 5'd0, 1'b0},
            '{{9'b100001011, 9'b100001010, 8'd0}, 1'b0, 8'sd0, 8'sd0, 5'd0, 1'b0},
            '{{9'b110101111, 9'b110101010, 8'd0}, 1'b0, 8'sd0, 8'sd0, 5'd0, 1'b0}
        };

        // Every input is known from time zero; reset is held low, then released.
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        bit_window <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // First phase: the sender holds back often, the receiver more often,
        // so the result register fills up and the input side has to wait.
        tx_idle_pct = 34;
        rx_idle_pct = 67;
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].has_known)
            begin
                want.first = directed_rows[i].first;
                want.second = directed_rows[i].second;
                want.bits_used = directed_rows[i].used;
                want.code_error = directed_rows[i].err;
            end
            else
            begin
                want = decode_pair(directed_rows[i].window);
            end
            send_window(directed_rows[i].window, want);
        end

        // Random windows in three phases: the first keeps these idle rates, the second
        // swaps them, then both sides run flat out so that a transfer can happen every cycle.
        for (int phase = 0; phase < 3; phase++)
        begin
            if (phase == 1)
            begin
                tx_idle_pct = 67;
                rx_idle_pct = 34;
            end
            else if (phase == 2)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            for (int n = 0; n < RandomPerPhase; n++)
            begin
                bit_window_draw: begin
                    win_t w;
                    w = random_window();
                    send_window(w, decode_pair(w));
                end
            end
        end
        in_valid <= 1'b0;

        // Wait for every pending result, then a few more cycles so that a
        // stray extra result would still be seen by the checker.
        while (pending_pairs.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
